// ===== sv/sacl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and field widths of the set-associative cache with age LRU.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int WORD_W   = 32;
    localparam int TAG_W    = 32;
    localparam int SET_IN_W = 4;
    localparam int OFF_IN_W = 3;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_FILL = 3'b100
    } state_t;

endpackage
`default_nettype wire

// ===== sv/sacl_victim.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_victim
// Pick the way to fill on a write miss: lowest empty way, else oldest way.
// ----------------------------------------------------------------------------
module sacl_victim #(
    parameter int WAYS  = 4,
    parameter int AGE_W = 8,
    parameter int WW    = 2
) (
    input  wire logic [WAYS-1:0]             valid,
    input  wire logic [WAYS-1:0][AGE_W-1:0]  ages,
    output logic      [WW-1:0]               way
);

    logic [WW-1:0]    empty_way;
    logic             any_empty;
    logic [WW-1:0]    old_way;
    logic [AGE_W-1:0] old_age;

    always_comb
    begin
        any_empty = 1'b0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!valid[w])
            begin
                any_empty = 1'b1;
                empty_way = WW'(w);
            end
        end
        old_way = '0;
        old_age = ages[0];
        for (int w = 1; w < WAYS; w++)
        begin
            // strict compare keeps the lowest way on a tie
            if (ages[w] > old_age)
            begin
                old_way = WW'(w);
                old_age = ages[w];
            end
        end
        way = any_empty ? empty_way : old_way;
    end

endmodule
`default_nettype wire

// ===== sv/set_assoc_cache_age_lru_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_age_lru_top
// Set-associative word cache with saturating age counters for LRU replacement.
// ----------------------------------------------------------------------------
// Issue an access by raising start while busy is low. On a read, the tag row
// and the word row of the set are read from their memories in the accept
// cycle, compared in the next, and the registered result word shows on hit
// and read_word for one cycle under result_valid. The receiver cannot stall,
// so sample the word on that strobe. A write hit updates its word in place.
// A write miss rewrites the block one word per cycle through the single
// word-memory write port (new word at the offset, zero elsewhere). Writes
// return no word. Every access ages all valid lines by one before the
// lookup, saturating at AGE_MAX. Set and offset inputs beyond the configured
// sizes wrap modulo those sizes.
// ----------------------------------------------------------------------------
module set_assoc_cache_age_lru_top
    import sacl_pkg::*;
#(
    parameter int WAYS        = 4,
    parameter int SETS        = 16,
    parameter int BLOCK_WORDS = 8,
    parameter int AGE_MAX     = 255
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 action,
    input  wire logic [TAG_W-1:0]     line_tag,
    input  wire logic [SET_IN_W-1:0]  set_index,
    input  wire logic [OFF_IN_W-1:0]  word_offset,
    input  wire logic [WORD_W-1:0]    write_value,
    output logic                      result_valid,
    output logic                      hit,
    output logic [WORD_W-1:0]         read_word
);

    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int OW    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int DEPTH = SETS * BLOCK_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AGE_W = $clog2(AGE_MAX + 1);

    // wrap set and offset through small constant tables
    function automatic logic [SW-1:0] wrap_set(input logic [SET_IN_W-1:0] s);
        logic [SW-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << SET_IN_W); i++)
        begin
            if (s == SET_IN_W'(i))
                r = SW'(i % SETS);
        end
        return r;
    endfunction

    function automatic logic [OW-1:0] wrap_off(input logic [OFF_IN_W-1:0] o);
        logic [OW-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << OFF_IN_W); i++)
        begin
            if (o == OFF_IN_W'(i))
                r = OW'(i % BLOCK_WORDS);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] word_addr(input logic [SW-1:0] s,
                                                input logic [OW-1:0] o);
        return AW'(int'(s) * BLOCK_WORDS + int'(o));
    endfunction

    function automatic logic [AGE_W-1:0] age_inc(input logic v,
                                                 input logic [AGE_W-1:0] a);
        return (v && a < AGE_W'(AGE_MAX)) ? a + 1'b1 : a;
    endfunction

    // control and latched access
    state_t              state_reg, state_next;
    logic                action_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [SW-1:0]       set_reg;
    logic [OW-1:0]       off_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [OW-1:0]       fill_cnt_reg, fill_cnt_next;
    logic [WW-1:0]       fill_way_reg, fill_way_next;

    // line state in flops, tags and words in memories
    logic [WAYS-1:0]               valid_reg [SETS];
    logic [WAYS-1:0][AGE_W-1:0]    age_reg   [SETS];
    logic [WAYS-1:0][AGE_W-1:0]    age_next  [SETS];
    logic [WAYS-1:0][TAG_W-1:0]    tag_mem   [SETS];
    logic [WAYS-1:0][WORD_W-1:0]   word_mem  [DEPTH];
    logic [WAYS-1:0][TAG_W-1:0]    tag_row_reg;
    logic [WAYS-1:0][WORD_W-1:0]   word_row_reg;

    logic                result_valid_reg;
    logic                hit_reg;
    logic [WORD_W-1:0]   read_word_reg;

    logic                accept;
    logic [WAYS-1:0]     row_valid;
    logic [WAYS-1:0][AGE_W-1:0] row_aged;
    logic [WAYS-1:0]     hit_vec;
    logic                found;
    logic [WW-1:0]       hit_way;
    logic [WW-1:0]       victim_way;
    logic                fill_start;
    logic                tag_we;
    logic                word_we;
    logic [AW-1:0]       word_wr_addr;
    logic [WW-1:0]       word_wr_way;
    logic [WORD_W-1:0]   word_wr_data;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // lookup of the latched set: aged view, tag compare, first hit way
    always_comb
    begin
        row_valid = valid_reg[set_reg];
        found     = 1'b0;
        hit_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            row_aged[w] = age_inc(row_valid[w], age_reg[set_reg][w]);
            hit_vec[w]  = row_valid[w] && (tag_row_reg[w] == tag_reg);
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                found   = 1'b1;
                hit_way = WW'(w);
            end
        end
    end

    sacl_victim #(
        .WAYS  (WAYS),
        .AGE_W (AGE_W),
        .WW    (WW)
    ) u_victim (
        .valid (row_valid),
        .ages  (row_aged),
        .way   (victim_way)
    );

    assign fill_start = (state_reg == ST_LOOK) && (action_reg == ACT_WRITE) && !found;
    assign tag_we     = fill_start;

    // sequencer and word-memory write selection
    always_comb
    begin
        state_next    = state_reg;
        fill_cnt_next = fill_cnt_reg;
        fill_way_next = fill_way_reg;
        word_we       = 1'b0;
        word_wr_addr  = word_addr(set_reg, off_reg);
        word_wr_way   = hit_way;
        word_wr_data  = value_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                state_next = ST_IDLE;
                if (action_reg == ACT_WRITE)
                begin
                    if (found)
                        word_we = 1'b1;
                    else
                    begin
                        // sweep the block of the chosen way
                        state_next    = ST_FILL;
                        fill_cnt_next = '0;
                        fill_way_next = victim_way;
                    end
                end
            end
            ST_FILL:
            begin
                word_we      = 1'b1;
                word_wr_addr = word_addr(set_reg, fill_cnt_reg);
                word_wr_way  = fill_way_reg;
                word_wr_data = (fill_cnt_reg == off_reg) ? value_reg : '0;
                if (fill_cnt_reg == OW'(BLOCK_WORDS - 1))
                    state_next = ST_IDLE;
                else
                    fill_cnt_next = fill_cnt_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // age every valid line once per access, then clear the touched line
    always_comb
    begin
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (state_reg == ST_LOOK)
                    age_next[s][w] = age_inc(valid_reg[s][w], age_reg[s][w]);
                else
                    age_next[s][w] = age_reg[s][w];
            end
        end
        if (state_reg == ST_LOOK)
        begin
            if (found)
                age_next[set_reg][hit_way] = '0;
            else if (fill_start)
                age_next[set_reg][victim_way] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_cnt_reg     <= '0;
            fill_way_reg     <= '0;
            result_valid_reg <= 1'b0;
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
                age_reg[s]   <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            fill_cnt_reg     <= fill_cnt_next;
            fill_way_reg     <= fill_way_next;
            result_valid_reg <= (state_reg == ST_LOOK) && (action_reg == ACT_READ);
            for (int s = 0; s < SETS; s++)
                age_reg[s] <= age_next[s];
            if (fill_start)
                valid_reg[set_reg][victim_way] <= 1'b1;
        end
    end

    // latch the access and read both memory rows of the set
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg   <= action;
            tag_reg      <= line_tag;
            set_reg      <= wrap_set(set_index);
            off_reg      <= wrap_off(word_offset);
            value_reg    <= write_value;
            tag_row_reg  <= tag_mem[wrap_set(set_index)];
            word_row_reg <= word_mem[word_addr(wrap_set(set_index),
                                               wrap_off(word_offset))];
        end
        if (tag_we)
            tag_mem[set_reg][victim_way] <= tag_reg;
        if (word_we)
            word_mem[word_wr_addr][word_wr_way] <= word_wr_data;
    end

    // hold the result word for its single strobe cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK)
        begin
            hit_reg       <= found;
            read_word_reg <= found ? word_row_reg[hit_way] : '1;
        end
    end

    assign result_valid = result_valid_reg;
    assign hit          = hit_reg;
    assign read_word    = read_word_reg;

`ifndef NO_ASSERTIONS
    a_strobe_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_LOOK) && $past(action_reg == ACT_READ))
        else $error("result strobe without a read lookup");

    a_miss_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !hit) |-> (read_word == '1))
        else $error("read miss word is not all ones");

    a_fill_from_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && $past(state_reg) != ST_FILL) |->
            $past(fill_start))
        else $error("block fill entered without a write miss");

    a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOK))
        else $error("accepted access did not enter lookup");
`endif

endmodule
`default_nettype wire
